// ===== hw/rtl/ntl_pkg.sv =====
// shared types and constants of the n-gram trie lookup block
package ntl_pkg;

  localparam int unsigned DefMaxOrder  = 4;
  localparam int unsigned DefEntryBits = 16;
  localparam int unsigned DefValueBits = 16;

  localparam logic [1:0] CfgModelOrder  = 2'd0;
  localparam logic [1:0] CfgMaxUnigram  = 2'd1;
  localparam logic [1:0] CfgUnknownCost = 2'd2;

  localparam logic OpQuery = 1'b0;
  localparam logic OpWrite = 1'b1;

  typedef struct packed {
    logic        op;
    logic [1:0]  level;
    logic [15:0] entry_index;
    logic [15:0] word_id;
    logic [15:0] prob_value;
    logic [15:0] bow_value;
    logic [15:0] child_first;
    logic [16:0] child_count;
    logic        last_word;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  matched_order;
    logic [15:0] prob;
    logic [15:0] backoff;
  } out_item_t;

endpackage

// ===== hw/rtl/ntl_ram.sv =====
// generic single-port ram with registered read
module ntl_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  // write or read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else begin
      rdata_o <= mem[addr_i];
    end
  end
endmodule

// ===== hw/rtl/ngram_trie_lookup_top.sv =====
// top level of the n-gram trie lookup block
// One item is handled at a time. A write is done in StL0. A query word at level 0 reads its
// tuple address in StL0, then goes through StTup and StDone, or straight to StDone when it
// misses at once. At a higher level a binary search over the child range takes a ram read,
// then the compare, per probe, about log2 of the range and at most ENTRY_BITS probes, then
// reads of the two final bounds, one tuple read and the result state. All tables share
// one single-port ram of MAX_ORDER*2^ENTRY_BITS entries, whose read latency sets the pace.
// A result waits in an output register while the next item is taken; a marked word holds
// in its last state until that register is free.
module ngram_trie_lookup_top
  import ntl_pkg::*;
#(
  parameter int unsigned MAX_ORDER  = DefMaxOrder,
  parameter int unsigned ENTRY_BITS = DefEntryBits,
  parameter int unsigned VALUE_BITS = DefValueBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ntl_pkg::in_item_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ntl_pkg::out_item_t out_data_o
);
  localparam int unsigned LvlBits = $clog2(MAX_ORDER);
  localparam int unsigned AddrBits = LvlBits + ENTRY_BITS;
  localparam int unsigned OrdBits = $clog2(MAX_ORDER + 1);
  localparam int unsigned RamW = 16 + 2 * VALUE_BITS + 16 + 17;
  localparam logic [ENTRY_BITS-1:0] EntryMax = '1;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StL0   = 3'd1;
  localparam logic [2:0] StProbe = 3'd2;
  localparam logic [2:0] StLo   = 3'd3;
  localparam logic [2:0] StHi   = 3'd4;
  localparam logic [2:0] StTup  = 3'd5;
  localparam logic [2:0] StDone = 3'd6;

  logic [2:0] st_q, st_d;
  logic [2:0] model_order_q;
  logic [15:0] max_unigram_q, unknown_cost_q;
  logic [OrdBits-1:0] walk_level_q, walk_level_d;
  logic [15:0] range_first_q, range_first_d;
  logic [16:0] range_count_q, range_count_d;
  logic [15:0] held_prob_q, held_prob_d, held_bow_q, held_bow_d;
  logic miss_q, miss_d;
  in_item_t item_q;
  logic [ENTRY_BITS:0] lo_q, lo_d, hi_q, hi_d;
  logic mid_pend_q, mid_pend_d;
  logic [ENTRY_BITS:0] mid_q, mid_d;
  logic out_valid_q;
  out_item_t out_q;
  logic [OrdBits-1:0] order;
  logic ram_we;
  logic [AddrBits-1:0] ram_addr;
  logic [RamW-1:0] ram_wd, ram_rd;
  logic [LvlBits-1:0] wlvl;
  logic [15:0] rd_id, rd_cf;
  logic [VALUE_BITS-1:0] rd_p, rd_b;
  logic [16:0] rd_cc;
  logic [ENTRY_BITS:0] mid_calc, span;
  logic [17:0] hi_full;
  logic accept, emit;

  assign order = (32'(model_order_q) > MAX_ORDER) ? OrdBits'(MAX_ORDER)
                                                  : OrdBits'(model_order_q);
  assign wlvl = walk_level_q[LvlBits-1:0];
  assign {rd_id, rd_p, rd_b, rd_cf, rd_cc} = ram_rd;
  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (st_q != StIdle);
  assign mid_calc = (ENTRY_BITS+1)'((lo_q + hi_q) >> 1);
  assign span = hi_q - lo_q;
  assign hi_full = 18'(range_first_q) + 18'(range_count_q) - 18'd1;

  ntl_ram #(.Width(RamW), .Depth(MAX_ORDER << ENTRY_BITS)) u_ram (
    .clk_i(clk_i), .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wd), .rdata_o(ram_rd)
  );

  // sign-extend a stored value to 16 bits
  function automatic logic [15:0] vout(logic [VALUE_BITS-1:0] v);
    logic [31:0] e;
    e = 32'(signed'(v));
    return e[15:0];
  endfunction

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_order_q  <= 3'd3;
      max_unigram_q  <= 16'hFFFF;
      unknown_cost_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgModelOrder:  model_order_q  <= cfg_wdata_i[2:0];
        CfgMaxUnigram:  max_unigram_q  <= cfg_wdata_i;
        CfgUnknownCost: unknown_cost_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ram port and walk sequencer
  always_comb begin
    st_d = st_q;
    walk_level_d = walk_level_q;
    range_first_d = range_first_q;
    range_count_d = range_count_q;
    held_prob_d = held_prob_q;
    held_bow_d = held_bow_q;
    miss_d = miss_q;
    lo_d = lo_q;
    hi_d = hi_q;
    mid_pend_d = 1'b0;
    mid_d = mid_q;
    emit = 1'b0;
    ram_we = 1'b0;
    ram_addr = '0;
    ram_wd = {item_q.word_id, VALUE_BITS'(item_q.prob_value),
              VALUE_BITS'(item_q.bow_value), item_q.child_first, item_q.child_count};
    unique case (st_q)
      StIdle: ;
      StL0: begin
        if (item_q.op == OpWrite) begin
          ram_we = (32'(item_q.level) < MAX_ORDER);
          ram_addr = {LvlBits'(item_q.level), ENTRY_BITS'(item_q.entry_index)};
          st_d = StIdle;
        end else if (miss_q || walk_level_q >= order) begin
          miss_d = 1'b1;
          st_d = StDone;
        end else if (walk_level_q == '0) begin
          if (item_q.word_id > max_unigram_q ||
              32'(item_q.word_id) > 32'(EntryMax)) begin
            miss_d = 1'b1;
            st_d = StDone;
          end else begin
            ram_addr = {wlvl, ENTRY_BITS'(item_q.word_id)};
            st_d = StTup;
          end
        end else if (range_count_q == '0 || 32'(range_first_q) > 32'(EntryMax)) begin
          miss_d = 1'b1;
          st_d = StDone;
        end else begin
          lo_d = (ENTRY_BITS+1)'(range_first_q);
          hi_d = (32'(hi_full) > 32'(EntryMax)) ? (ENTRY_BITS+1)'(EntryMax)
                                                : (ENTRY_BITS+1)'(hi_full);
          st_d = StProbe;
        end
      end
      StProbe: begin
        // consume a pending probe; with none pending, issue the next one or read the low bound
        if (mid_pend_q) begin
          if (rd_id < item_q.word_id) begin
            lo_d = mid_q;
          end else if (rd_id > item_q.word_id) begin
            hi_d = mid_q;
          end else begin
            ram_addr = {wlvl, mid_q[ENTRY_BITS-1:0]};
            st_d = StTup;
          end
        end
        if (st_d == StProbe) begin
          if (!mid_pend_q && span > 1) begin
            mid_d = mid_calc;
            ram_addr = {wlvl, mid_calc[ENTRY_BITS-1:0]};
            mid_pend_d = 1'b1;
          end else if (!mid_pend_q) begin
            ram_addr = {wlvl, lo_q[ENTRY_BITS-1:0]};
            st_d = StLo;
          end
        end
      end
      StLo: begin
        if (rd_id == item_q.word_id) begin
          ram_addr = {wlvl, lo_q[ENTRY_BITS-1:0]};
          st_d = StTup;
        end else begin
          ram_addr = {wlvl, hi_q[ENTRY_BITS-1:0]};
          st_d = StHi;
        end
      end
      StHi: begin
        if (rd_id == item_q.word_id) begin
          ram_addr = {wlvl, hi_q[ENTRY_BITS-1:0]};
          st_d = StTup;
        end else begin
          miss_d = 1'b1;
          st_d = StDone;
        end
      end
      StTup: begin
        held_prob_d = vout(rd_p);
        if (walk_level_q + 1'b1 < order) begin
          held_bow_d = vout(rd_b);
          range_first_d = rd_cf;
          range_count_d = rd_cc;
        end else begin
          held_bow_d = '0;
          range_first_d = '0;
          range_count_d = '0;
        end
        walk_level_d = walk_level_q + 1'b1;
        st_d = StDone;
      end
      StDone: begin
        // a marked word waits here until the output register is free
        if (!item_q.last_word) begin
          st_d = StIdle;
        end else if (!out_valid_q || !out_stall_i) begin
          st_d = StIdle;
          emit = 1'b1;
          walk_level_d = '0;
          range_first_d = '0;
          range_count_d = '0;
          held_prob_d = unknown_cost_q;
          held_bow_d = '0;
          miss_d = 1'b0;
        end
      end
      default: st_d = StIdle;
    endcase
    if (accept) st_d = StL0;
  end

  // sequencer and walk registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      walk_level_q <= '0;
      range_first_q <= '0;
      range_count_q <= '0;
      held_prob_q <= '0;
      held_bow_q <= '0;
      miss_q <= 1'b0;
      mid_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      walk_level_q <= walk_level_d;
      range_first_q <= range_first_d;
      range_count_q <= range_count_d;
      held_prob_q <= (walk_level_d == '0) ? unknown_cost_q : held_prob_d;
      held_bow_q <= held_bow_d;
      miss_q <= miss_d;
      mid_pend_q <= mid_pend_d;
      if (emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_data_i;
    lo_q <= lo_d;
    hi_q <= hi_d;
    mid_q <= mid_d;
    if (emit) begin
      out_q.matched_order <= 3'(walk_level_q);
      out_q.prob <= (walk_level_q == '0) ? unknown_cost_q : held_prob_q;
      out_q.backoff <= (walk_level_q == '0) ? 16'd0 : held_bow_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  // checks
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_level_q <= OrdBits'(MAX_ORDER)) else $error("walk level past max order");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle) |-> !accept) else $error("item taken while busy");
  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (walk_level_q == '0 && !miss_q)) else $error("walk not cleared");
endmodule
